### sv/pheromone_grid_diffuse_evaporate_defines.svh
// Assertion macros for the pheromone grid diffuse/evaporate RTL.
`ifndef PHEROMONE_GRID_DIFFUSE_EVAPORATE_DEFINES_SVH
`define PHEROMONE_GRID_DIFFUSE_EVAPORATE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication check
`define PGDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgde: same-cycle check failed");

// Next-cycle implication check
`define PGDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgde: next-cycle check failed");

`else

`define PGDE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PGDE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/pgde_pkg.sv
// Shared types, constants and helpers for the pheromone grid diffuse/evaporate block.
package pgde_pkg;

    // Field and register widths
    localparam int LEVEL_W     = 18;
    localparam int GAIN_W      = 16;
    localparam int SIZE_W      = 9;
    localparam int POS_W       = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Default grid limits
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0] GRID_WIDTH_RST       = 9'd256;
    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST      = 9'd256;
    localparam logic [GAIN_W-1:0] DIFFUSION_GAIN_RST   = 16'd62259;
    localparam logic [GAIN_W-1:0] EVAPORATION_GAIN_RST = 16'd64880;

    // Diagonal neighbor weight, about 1/sqrt(2) in Q0.16
    localparam logic [GAIN_W-1:0] DIAG_WEIGHT = 16'd46341;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH       = 3'd0,
        REG_GRID_HEIGHT      = 3'd1,
        REG_DIFFUSION_GAIN   = 3'd2,
        REG_EVAPORATION_GAIN = 3'd3,
        REG_PASS_MODE        = 3'd4
    } pgde_reg_t;

    // Input cell payload
    typedef struct packed {
        logic               first_of_frame;
        logic [LEVEL_W-1:0] food_level;
        logic [LEVEL_W-1:0] home_level;
    } pgde_in_t;

    // Result payload
    typedef struct packed {
        logic [POS_W-1:0]   cell_row;
        logic [POS_W-1:0]   cell_col;
        logic [LEVEL_W-1:0] new_food;
        logic [LEVEL_W-1:0] new_home;
    } pgde_out_t;

    // Per-lane stage controls from the sequencer
    typedef struct packed {
        logic shift;
        logic peak;
        logic scale;
        logic evap;
    } pgde_lane_ctl_t;

    // Q0.16 gain times Q10.8 level, truncated back to Q10.8
    function automatic logic [LEVEL_W-1:0] scale_level(
        input logic [GAIN_W-1:0]  gain,
        input logic [LEVEL_W-1:0] level
    );
        logic [GAIN_W+LEVEL_W-1:0] prod;
        prod = (GAIN_W+LEVEL_W)'(gain) * (GAIN_W+LEVEL_W)'(level);
        return prod[GAIN_W+LEVEL_W-1:GAIN_W];
    endfunction

endpackage

### sv/pheromone_grid_diffuse_evaporate.sv
// Pheromone grid diffusion/evaporation over a raster stream of cells, food and home lanes.
//
// Cells enter in raster order, one per transfer, and each goes through these steps: a read of
// the line stores on transfer, their write back with capture of the 3x3 window, then the
// neighbor max and the gain multiply of each lane's pipeline, then the update into the result
// register. The result register lets the next cell enter while a result still waits; a cell
// stalls in settle only if it has a result and the previous result is not taken. In diffusion
// mode a result appears for interior cells only, one row and one column behind the cell
// that completed its window; border cells give none. In evaporation mode every cell gives
// one result. Line stores hold MAX_WIDTH entries and need no clearing after reset: a frame
// must feed two full rows before diffused values are meaningful.

`include "pheromone_grid_diffuse_evaporate_defines.svh"

module pheromone_grid_diffuse_evaporate #(
    parameter int MAX_WIDTH  = pgde_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pgde_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cell_valid,
    output logic                                cell_ready,
    input  pgde_pkg::pgde_in_t                  cell_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output pgde_pkg::pgde_out_t                 result,
    input  logic                                cfg_en,
    input  logic [pgde_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pgde_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pgde_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int SWH = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOAD   = 5'b00010,
        ST_PEAK   = 5'b00100,
        ST_SCALE  = 5'b01000,
        ST_SETTLE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [SIZE_W-1:0] grid_width_reg;
    logic [SIZE_W-1:0] grid_height_reg;
    logic [GAIN_W-1:0] diffusion_gain_reg;
    logic [GAIN_W-1:0] evaporation_gain_reg;
    logic              pass_mode_reg;

    // Position counters
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;

    // Current cell context
    pgde_in_t         cur_reg;
    logic [CW-1:0]    addr_reg;
    logic [POS_W-1:0] pos_row_reg, pos_row_next;
    logic [POS_W-1:0] pos_col_reg, pos_col_next;
    logic             emit_reg, emit_next;
    logic             evap_reg;

    // Result register
    pgde_out_t result_reg;
    logic      result_valid_reg;

    logic           cell_xfer;
    logic           slot_free;
    logic           settle_emit;
    logic           settle_done;
    logic [CW-1:0]  col_cur;
    logic [RW-1:0]  row_cur;
    logic [CW-1:0]  col_m1;
    logic [RW-1:0]  row_m1;
    logic [SWW-1:0] w_raw, w_eff;
    logic [SWH-1:0] h_raw, h_eff;

    logic [2*LEVEL_W-1:0] rd_upper, rd_lower;
    logic [2*LEVEL_W-1:0] cur_pair;
    pgde_lane_ctl_t       lane_ctl;
    logic [LEVEL_W-1:0]   food_new, home_new;

    assign cell_ready   = (state_reg == ST_IDLE);
    assign cell_xfer    = cell_valid && cell_ready;
    assign slot_free    = !result_valid_reg || result_ready;
    assign settle_emit  = (state_reg == ST_SETTLE) && emit_reg;
    assign settle_done  = (state_reg == ST_SETTLE) && (!emit_reg || slot_free);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg       <= GRID_WIDTH_RST;
            grid_height_reg      <= GRID_HEIGHT_RST;
            diffusion_gain_reg   <= DIFFUSION_GAIN_RST;
            evaporation_gain_reg <= EVAPORATION_GAIN_RST;
            pass_mode_reg        <= 1'b0;
        end
        else if (cfg_en)
        begin
            unique case (pgde_reg_t'(cfg_index))
                REG_GRID_WIDTH:       grid_width_reg       <= cfg_data[SIZE_W-1:0];
                REG_GRID_HEIGHT:      grid_height_reg      <= cfg_data[SIZE_W-1:0];
                REG_DIFFUSION_GAIN:   diffusion_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_EVAPORATION_GAIN: evaporation_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_PASS_MODE:        pass_mode_reg        <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Effective grid size, clamped to 3..MAX
    always_comb
    begin
        w_raw = SWW'(grid_width_reg);
        h_raw = SWH'(grid_height_reg);
        if (w_raw < SWW'(3))
            w_eff = SWW'(3);
        else if (w_raw > SWW'(MAX_WIDTH))
            w_eff = SWW'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw < SWH'(3))
            h_eff = SWH'(3);
        else if (h_raw > SWH'(MAX_HEIGHT))
            h_eff = SWH'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    // Position of the incoming cell, next counters and emit decision
    always_comb
    begin
        col_cur = cell_data.first_of_frame ? '0 : col_count_reg;
        row_cur = cell_data.first_of_frame ? '0 : row_count_reg;
        col_m1  = col_cur - CW'(1);
        row_m1  = row_cur - RW'(1);

        if (SWW'(col_cur) + SWW'(1) >= w_eff)
        begin
            col_count_next = '0;
            row_count_next = (SWH'(row_cur) + SWH'(1) >= h_eff) ? '0 : row_cur + RW'(1);
        end
        else
        begin
            col_count_next = col_cur + CW'(1);
            row_count_next = row_cur;
        end

        if (pass_mode_reg)
        begin
            emit_next    = 1'b1;
            pos_row_next = POS_W'(row_cur);
            pos_col_next = POS_W'(col_cur);
        end
        else
        begin
            emit_next    = (SWH'(row_cur) >= SWH'(2)) && (SWW'(col_cur) >= SWW'(2))
                           && (SWH'(row_cur) < h_eff) && (SWW'(col_cur) < w_eff);
            pos_row_next = POS_W'(row_m1);
            pos_col_next = POS_W'(col_m1);
        end
    end

    // Counters and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cell_xfer)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
        end
    end

    // Cell context, captured on transfer
    always_ff @(posedge clk)
    begin
        if (cell_xfer)
        begin
            cur_reg     <= cell_data;
            addr_reg    <= col_cur;
            pos_row_reg <= pos_row_next;
            pos_col_reg <= pos_col_next;
            emit_reg    <= emit_next;
            evap_reg    <= pass_mode_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (cell_xfer) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_PEAK;
            ST_PEAK:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_SETTLE;
            ST_SETTLE: if (settle_done) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign lane_ctl.shift = (state_reg == ST_LOAD);
    assign lane_ctl.peak  = (state_reg == ST_PEAK);
    assign lane_ctl.scale = (state_reg == ST_SCALE);
    assign lane_ctl.evap  = evap_reg;

    assign cur_pair = {cur_reg.home_level, cur_reg.food_level};

    // Line stores: read on transfer, write back during the load cycle
    pgde_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk      (clk),
        .rd_en    (cell_xfer),
        .rd_addr  (col_cur),
        .wr_en    (lane_ctl.shift),
        .wr_addr  (addr_reg),
        .wr_upper (rd_lower),
        .wr_lower (cur_pair),
        .rd_upper (rd_upper),
        .rd_lower (rd_lower)
    );

    // Food lane
    pgde_lane u_food_lane (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (lane_ctl),
        .top_level        (rd_upper[LEVEL_W-1:0]),
        .mid_level        (rd_lower[LEVEL_W-1:0]),
        .cur_level        (cur_reg.food_level),
        .diffusion_gain   (diffusion_gain_reg),
        .evaporation_gain (evaporation_gain_reg),
        .new_level        (food_new)
    );

    // Home lane
    pgde_lane u_home_lane (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (lane_ctl),
        .top_level        (rd_upper[2*LEVEL_W-1:LEVEL_W]),
        .mid_level        (rd_lower[2*LEVEL_W-1:LEVEL_W]),
        .cur_level        (cur_reg.home_level),
        .diffusion_gain   (diffusion_gain_reg),
        .evaporation_gain (evaporation_gain_reg),
        .new_level        (home_new)
    );

    // Merge lanes into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (settle_done && emit_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (settle_done && emit_reg)
        begin
            result_reg.cell_row <= pos_row_reg;
            result_reg.cell_col <= pos_col_reg;
            result_reg.new_food <= food_new;
            result_reg.new_home <= home_new;
        end
    end

    // Checks
    `PGDE_ASSERT_NEXT(a_xfer_starts_load, clk, rst_n, cell_xfer, state_reg == ST_LOAD)
    `PGDE_ASSERT_NEXT(a_settle_holds, clk, rst_n, settle_emit && !slot_free, state_reg == ST_SETTLE)
    `PGDE_ASSERT_NEXT(a_result_loaded, clk, rst_n, settle_emit && slot_free, result_valid_reg && cell_ready)

endmodule

### sv/pgde_line_store.sv
// Two row line stores holding both pheromone lanes of the previous two grid rows.
module pgde_line_store #(
    parameter int DEPTH = pgde_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [2*pgde_pkg::LEVEL_W-1:0]   wr_upper,
    input  logic [2*pgde_pkg::LEVEL_W-1:0]   wr_lower,
    output logic [2*pgde_pkg::LEVEL_W-1:0]   rd_upper,
    output logic [2*pgde_pkg::LEVEL_W-1:0]   rd_lower
);
    import pgde_pkg::*;

    logic [2*LEVEL_W-1:0] upper_mem [DEPTH];
    logic [2*LEVEL_W-1:0] lower_mem [DEPTH];
    logic [2*LEVEL_W-1:0] rd_upper_reg;
    logic [2*LEVEL_W-1:0] rd_lower_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr] <= wr_upper;
            lower_mem[wr_addr] <= wr_lower;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_upper_reg <= upper_mem[rd_addr];
            rd_lower_reg <= lower_mem[rd_addr];
        end
    end

    assign rd_upper = rd_upper_reg;
    assign rd_lower = rd_lower_reg;

endmodule

### sv/pgde_lane.sv
// One pheromone lane: 3x3 window columns, weighted neighbor max, gain multiply, update rule.
module pgde_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pgde_pkg::pgde_lane_ctl_t       ctl,
    input  logic [pgde_pkg::LEVEL_W-1:0]   top_level,
    input  logic [pgde_pkg::LEVEL_W-1:0]   mid_level,
    input  logic [pgde_pkg::LEVEL_W-1:0]   cur_level,
    input  logic [pgde_pkg::GAIN_W-1:0]    diffusion_gain,
    input  logic [pgde_pkg::GAIN_W-1:0]    evaporation_gain,
    output logic [pgde_pkg::LEVEL_W-1:0]   new_level
);
    import pgde_pkg::*;

    // win: 0..2 = column c-2 (top, mid, bottom), 3..5 = column c-1
    logic [LEVEL_W-1:0] win_reg  [6];
    logic [LEVEL_W-1:0] win_next [6];

    logic [LEVEL_W-1:0] ortho_reg [4];
    logic [LEVEL_W-1:0] diag_reg  [4];
    logic [LEVEL_W-1:0] old_reg;
    logic [LEVEL_W-1:0] cur_hold_reg;
    logic [LEVEL_W-1:0] peak_reg;
    logic [LEVEL_W-1:0] prod_reg;

    logic [LEVEL_W-1:0] max_a, max_b, max_c, max_d, max_e, max_f, max_all;
    logic [GAIN_W-1:0]  gain_sel;

    function automatic logic [LEVEL_W-1:0] max2(
        input logic [LEVEL_W-1:0] a,
        input logic [LEVEL_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // Window shift: new column enters at the right
    always_comb
    begin
        win_next[0] = win_reg[3];
        win_next[1] = win_reg[4];
        win_next[2] = win_reg[5];
        win_next[3] = top_level;
        win_next[4] = mid_level;
        win_next[5] = cur_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ctl.shift)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Stage 1: neighbor capture and diagonal weighting
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            ortho_reg[0] <= win_reg[1];
            ortho_reg[1] <= win_reg[3];
            ortho_reg[2] <= win_reg[5];
            ortho_reg[3] <= mid_level;
            diag_reg[0]  <= scale_level(DIAG_WEIGHT, win_reg[0]);
            diag_reg[1]  <= scale_level(DIAG_WEIGHT, win_reg[2]);
            diag_reg[2]  <= scale_level(DIAG_WEIGHT, top_level);
            diag_reg[3]  <= scale_level(DIAG_WEIGHT, cur_level);
            old_reg      <= win_reg[4];
            cur_hold_reg <= cur_level;
        end
    end

    // Stage 2: max over the eight weighted neighbors, or the current level in evaporation mode
    always_comb
    begin
        max_a   = max2(ortho_reg[0], ortho_reg[1]);
        max_b   = max2(ortho_reg[2], ortho_reg[3]);
        max_c   = max2(diag_reg[0], diag_reg[1]);
        max_d   = max2(diag_reg[2], diag_reg[3]);
        max_e   = max2(max_a, max_b);
        max_f   = max2(max_c, max_d);
        max_all = max2(max_e, max_f);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.peak)
        begin
            peak_reg <= ctl.evap ? cur_hold_reg : max_all;
        end
    end

    // Stage 3: shared gain multiplier
    assign gain_sel = ctl.evap ? evaporation_gain : diffusion_gain;

    always_ff @(posedge clk)
    begin
        if (ctl.scale)
        begin
            prod_reg <= scale_level(gain_sel, peak_reg);
        end
    end

    // Update rule: in evaporation mode the candidate always wins; else it wins if larger or if the old level is empty
    always_comb
    begin
        if (ctl.evap || (old_reg < prod_reg) || (old_reg == '0))
        begin
            new_level = prod_reg;
        end
        else
        begin
            new_level = old_reg;
        end
    end

endmodule

### sim/pgde_tb_pkg.sv
// Scoreboard class with the cell-stream predictor for the pheromone grid testbench.
`timescale 1ns / 100ps
package pgde_tb_pkg;
    import pgde_pkg::*;

    typedef logic [LEVEL_W-1:0] level_t;

    localparam int LINE_DEPTH = MAX_WIDTH_DEF;
    localparam int ROW_LIMIT  = MAX_HEIGHT_DEF;

    class pheromone_grid_scoreboard;
        // register copies
        logic [SIZE_W-1:0] grid_width;
        logic [SIZE_W-1:0] grid_height;
        logic [GAIN_W-1:0] diffusion_gain;
        logic [GAIN_W-1:0] evaporation_gain;
        logic              evaporate;

        // grid state, lane 0 food, lane 1 home
        level_t upper_line [LINE_DEPTH][2];
        level_t lower_line [LINE_DEPTH][2];
        level_t window [6][2];
        int     row_count;
        int     col_count;

        pgde_out_t expected_cells[$];
        int        errors;

        function new();
            grid_width       = GRID_WIDTH_RST;
            grid_height      = GRID_HEIGHT_RST;
            diffusion_gain   = DIFFUSION_GAIN_RST;
            evaporation_gain = EVAPORATION_GAIN_RST;
            evaporate        = 1'b0;
            foreach (upper_line[i, j])
            begin
                upper_line[i][j] = '0;
                lower_line[i][j] = '0;
            end
            foreach (window[i, j])
                window[i][j] = '0;
            row_count = 0;
            col_count = 0;
            errors    = 0;
        endfunction

        function void set_reg(pgde_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_GRID_WIDTH:       grid_width = value[SIZE_W-1:0];
                REG_GRID_HEIGHT:      grid_height = value[SIZE_W-1:0];
                REG_DIFFUSION_GAIN:   diffusion_gain = value[GAIN_W-1:0];
                REG_EVAPORATION_GAIN: evaporation_gain = value[GAIN_W-1:0];
                REG_PASS_MODE:        evaporate = value[0];
                default: ;
            endcase
        endfunction

        // sizes below 3 act as 3, sizes above the line depth act as the maximum
        function int frame_width();
            if (grid_width < 3)
                return 3;
            if (grid_width > LINE_DEPTH)
                return LINE_DEPTH;
            return int'(grid_width);
        endfunction

        function int frame_height();
            if (grid_height < 3)
                return 3;
            if (grid_height > ROW_LIMIT)
                return ROW_LIMIT;
            return int'(grid_height);
        endfunction

        // Q0.16 gain times Q10.8 level, truncated
        static function level_t gain_product(logic [GAIN_W-1:0] gain, level_t level);
            logic [GAIN_W+LEVEL_W-1:0] wide;
            wide = {{LEVEL_W{1'b0}}, gain} * {{GAIN_W{1'b0}}, level};
            return wide[GAIN_W+LEVEL_W-1:GAIN_W];
        endfunction

        // strongest weighted neighbor times the gain; replaces a smaller or empty level
        function level_t diffuse(int lane, level_t top, level_t mid, level_t bot);
            level_t around [8];
            level_t peak;
            level_t cand;
            level_t old;
            old    = window[4][lane];
            around = '{window[1][lane], window[3][lane], window[5][lane], mid,
                       gain_product(DIAG_WEIGHT, window[0][lane]),
                       gain_product(DIAG_WEIGHT, window[2][lane]),
                       gain_product(DIAG_WEIGHT, top),
                       gain_product(DIAG_WEIGHT, bot)};
            peak = '0;
            foreach (around[k])
                if (around[k] > peak)
                    peak = around[k];
            cand = gain_product(diffusion_gain, peak);
            if (old < cand || old == '0)
                return cand;
            return old;
        endfunction

        // append one expected result at the tail of the queue
        function void queue_expected(pgde_out_t res);
            expected_cells.insert(expected_cells.size(), res);
        endfunction

        // one accepted cell: queue its result, if any, then advance the grid state
        function void accept_cell(pgde_in_t c);
            int        w;
            int        h;
            int        ci;
            level_t    cur [2];
            level_t    top [2];
            level_t    mid [2];
            pgde_out_t res;
            w = frame_width();
            h = frame_height();
            if (c.first_of_frame)
            begin
                row_count = 0;
                col_count = 0;
            end
            ci     = col_count % LINE_DEPTH;
            cur[0] = c.food_level;
            cur[1] = c.home_level;
            for (int lane = 0; lane < 2; lane++)
            begin
                top[lane] = upper_line[ci][lane];
                mid[lane] = lower_line[ci][lane];
            end

            if (evaporate)
            begin
                res.cell_row = POS_W'(row_count);
                res.cell_col = POS_W'(col_count);
                res.new_food = gain_product(evaporation_gain, cur[0]);
                res.new_home = gain_product(evaporation_gain, cur[1]);
                queue_expected(res);
            end
            else if (row_count >= 2 && col_count >= 2 && row_count < h && col_count < w)
            begin
                res.cell_row = POS_W'(row_count - 1);
                res.cell_col = POS_W'(col_count - 1);
                res.new_food = diffuse(0, top[0], mid[0], cur[0]);
                res.new_home = diffuse(1, top[1], mid[1], cur[1]);
                queue_expected(res);
            end

            // line stores and window move in both modes
            for (int lane = 0; lane < 2; lane++)
            begin
                upper_line[ci][lane] = mid[lane];
                lower_line[ci][lane] = cur[lane];
                window[0][lane] = window[3][lane];
                window[1][lane] = window[4][lane];
                window[2][lane] = window[5][lane];
                window[3][lane] = top[lane];
                window[4][lane] = mid[lane];
                window[5][lane] = cur[lane];
            end

            if (col_count + 1 >= w)
            begin
                col_count = 0;
                row_count = (row_count + 1 >= h) ? 0 : row_count + 1;
            end
            else
                col_count++;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(pgde_out_t got);
            pgde_out_t want;
            if (expected_cells.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual row %0d col %0d",
                         $time, got.cell_row, got.cell_col);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            compare_field("cell_row", want.cell_row, got.cell_row);
            compare_field("cell_col", want.cell_col, got.cell_col);
            compare_field("new_food", want.new_food, got.new_food);
            compare_field("new_home", want.new_home, got.new_home);
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

endpackage

### sim/tb.sv
// Top-level testbench: random-idling cell and result streams, register sweeps, result checks.
`timescale 1ns / 100ps
module tb;
    import pgde_pkg::*;
    import pgde_tb_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_CYCLES  = 12;
    localparam int LONG_HOLD     = 150;
    localparam int RANDOM_PHASES = 11;
    localparam int RUN_LIMIT_NS  = 6_000_000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // 4x4 diffusion frame: empty centers, saturated neighbors, diagonal-only peaks
    localparam level_t DIRECTED_FOOD [16] = '{
        18'd1000, 18'h3FFFF, 18'd7,     18'd0,
        18'd0,    18'd0,     18'h3FFFF, 18'd3,
        18'd5,    18'd20,    18'd9,     18'd1,
        18'd0,    18'h3FFFF, 18'd2,     18'd100000};
    localparam level_t DIRECTED_HOME [16] = '{
        18'h3FFFF, 18'd0, 18'd0, 18'd0,
        18'd0,     18'd0, 18'd0, 18'd0,
        18'd0,     18'd0, 18'd0, 18'd0,
        18'd0,     18'd0, 18'd0, 18'h3FFFF};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cell_valid = 1'b0;
    logic                   cell_ready;
    pgde_in_t               cell_data = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    pgde_out_t              result;
    logic                   cfg_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_done      = 0;

    pheromone_grid_scoreboard grid_sb = new();

    pheromone_grid_diffuse_evaporate i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_ready   (cell_ready),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Hard stop in case a handshake never completes
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: check each transfer, stall at random or for a long hold-off
    initial
    begin : receiver
        int held = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                grid_sb.check_result(result);
            if (hold_done != hold_req)
            begin
                result_ready <= 1'b0;
                held++;
                if (held == LONG_HOLD)
                begin
                    held = 0;
                    hold_done++;
                end
            end
            else
                result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic void set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = 60;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 60;
            end
            default:
            begin
                send_idle_pct  = 31;
                recv_stall_pct = 31;
            end
        endcase
    endfunction

    function automatic pgde_in_t make_cell(input bit first, input level_t food, input level_t home);
        pgde_in_t c;
        c.first_of_frame = first;
        c.food_level     = food;
        c.home_level     = home;
        return c;
    endfunction

    // zero, saturated, small and full-range levels
    function automatic level_t random_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return level_t'($urandom_range(0, 255));
            default: return level_t'($urandom());
        endcase
    endfunction

    function automatic int random_size();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 2);
            1:       return $urandom_range(257, 511);
            2:       return 3;
            default: return $urandom_range(3, 9);
        endcase
    endfunction

    function automatic int random_gain();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Offer one cell and wait for its transfer; valid stays high for a following cell
    task automatic send_cell(input pgde_in_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cell_valid <= 1'b0;
            @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_data  <= c;
        @(posedge clk);
        while (!cell_ready)
            @(posedge clk);
        grid_sb.accept_cell(c);
    endtask

    task automatic send_run(input int count, input bit start_frame, input bit stray_starts);
        for (int k = 0; k < count; k++)
            send_cell(make_cell(k == 0 ? start_frame
                                       : (stray_starts && $urandom_range(0, 3) == 0),
                                random_level(), random_level()));
    endtask

    // Stop offering, let every expected result arrive, then let the pipeline empty
    task automatic settle();
        cell_valid <= 1'b0;
        while (grid_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input pgde_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        grid_sb.set_reg(idx, value);
    endtask

    task automatic configure(input int w, input int h, input int dg, input int eg,
                             input bit evap);
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_DIFFUSION_GAIN, CFG_DATA_W'(dg));
        write_reg(REG_EVAPORATION_GAIN, CFG_DATA_W'(eg));
        write_reg(REG_PASS_MODE, CFG_DATA_W'(evap));
        cfg_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        int ew;
        int eh;
        int budget;
        int sent;
        int n;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: three full-width rows fill both line stores at every column;
        // the third row gives the first diffused results.
        set_idling(IDLE_BOTH);
        send_run(3 * LINE_DEPTH, 1'b1, 1'b0);
        settle();

        // Evaporation at the reset gain, only the mode written
        set_idling(IDLE_NONE);
        write_reg(REG_PASS_MODE, CFG_DATA_W'(1));
        cfg_en <= 1'b0;
        send_cell(make_cell(1'b0, '0, '1));
        send_cell(make_cell(1'b0, '1, 18'd1));
        settle();

        // Evaporation gain extremes
        configure(4, 4, 0, 65535, 1'b1);
        send_cell(make_cell(1'b1, '1, '0));
        send_cell(make_cell(1'b0, 18'h20000, 18'd1));
        settle();
        configure(4, 4, 0, 0, 1'b1);
        send_cell(make_cell(1'b0, '1, '1));
        settle();

        // Directed diffusion frame at full gain
        configure(4, 4, 65535, 0, 1'b0);
        for (int k = 0; k < 16; k++)
            send_cell(make_cell(k == 0, DIRECTED_FOOD[k], DIRECTED_HOME[k]));
        settle();

        // Oversized width: receiver holds off so the block fills and stalls its input
        configure(300, 2, random_gain(), random_gain(), 1'b1);
        hold_req++;
        send_run(LINE_DEPTH + 4, 1'b1, 1'b0);
        settle();

        // Random settings; mostly whole frames, some broken runs and stray frame starts
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_idling(idle_mode_t'(phase % 4));
            configure(random_size(), random_size(), random_gain(), random_gain(),
                      $urandom_range(0, 9) < 3);
            ew     = grid_sb.frame_width();
            eh     = grid_sb.frame_height();
            budget = $urandom_range(15, 35);
            sent   = 0;
            // counters left by the previous settings meet the new size
            if ($urandom_range(0, 1) == 1)
            begin
                n = $urandom_range(1, 3);
                send_run(n, 1'b0, 1'b0);
                sent += n;
            end
            while (sent < budget)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    n = ew * eh;
                    if (n > 100)
                        n = $urandom_range(10, 60);
                    send_run(n, 1'b1, 1'b0);
                end
                else
                begin
                    n = $urandom_range(1, 12);
                    send_run(n, $urandom_range(0, 1), 1'b1);
                end
                sent += n;
            end
            settle();
        end

        if (grid_sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
